>>> rtl/core/k_nearest_points_select_macros.svh
// Assertion macros shared by the k-nearest-points RTL.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef K_NEAREST_POINTS_SELECT_MACROS_SVH
`define K_NEAREST_POINTS_SELECT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define KNPS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When ante holds, cons must hold on the next edge.
`define KNPS_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/knps_pkg.sv
// Shared types and sizing constants for k_nearest_points_select.
// No dependencies; imported by every module of the block.
`default_nettype none

package knps_pkg;

  localparam int MAX_KEEP   = 32;                       // store depth
  localparam int COORD_BITS = 16;                       // coordinate width
  localparam int SUM_W      = 2 * COORD_BITS;           // exact squared distance
  localparam int DIST_W     = 32;                       // reported distance width
  localparam int KEEP_W     = 6;                        // cfg_keep_count input width
  localparam int CNT_W      = $clog2(MAX_KEEP + 1);     // 0..MAX_KEEP
  localparam int IDX_W      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int QDEPTH     = 2;                        // front-to-back queue depth
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [SUM_W-1:0]      sq_dist;
  } entry_t;

  typedef struct packed {
    entry_t pt;
    logic   set_end;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

`default_nettype wire

>>> rtl/core/knps_front.sv
// Front end: accepts points and computes exact squared distance in two stages.
// Depends on knps_pkg; feeds knps_queue.
`default_nettype none

module knps_front
  import knps_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_coord_x,
  input  wire logic signed [COORD_BITS-1:0] in_coord_y,
  input  wire logic                         in_set_end,
  output push_t                             push,
  input  wire logic                         q_full
);

  // stage 1: squares
  logic                         s1_valid_r, s1_valid_nxt;
  logic signed [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic                         s1_end_r;
  logic signed [SUM_W-1:0]      s1_sqx_r, s1_sqy_r;
  // stage 2: sum
  logic                         s2_valid_r, s2_valid_nxt;
  item_t                        s2_item_r;

  logic s1_adv, s2_adv, in_acc, do_push;

  assign do_push  = s2_valid_r && !q_full;
  assign s2_adv   = !s2_valid_r || do_push;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;

  assign s1_valid_nxt = s1_adv ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_adv ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r   <= in_coord_x;
      s1_y_r   <= in_coord_y;
      s1_end_r <= in_set_end;
      s1_sqx_r <= SUM_W'(in_coord_x) * SUM_W'(in_coord_x);
      s1_sqy_r <= SUM_W'(in_coord_y) * SUM_W'(in_coord_y);
    end
    if (s2_adv && s1_valid_r) begin
      s2_item_r.pt.x       <= s1_x_r;
      s2_item_r.pt.y       <= s1_y_r;
      s2_item_r.pt.sq_dist <= $unsigned(s1_sqx_r) + $unsigned(s1_sqy_r);
      s2_item_r.set_end    <= s1_end_r;
    end
  end

  assign push.valid = do_push;
  assign push.item  = s2_item_r;

endmodule

`default_nettype wire

>>> rtl/core/knps_queue.sv
// Short queue between front and back ends.
// Depends on knps_pkg and the assertion macro header.
`default_nettype none
`include "k_nearest_points_select_macros.svh"

module knps_queue
  import knps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  push_t      push,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output item_t      head
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push.valid && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)        rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr_r] <= push.item;
  end

  `KNPS_ASSERT(a_q_no_overflow, !(push.valid && full), "queue push while full")
  `KNPS_ASSERT(a_q_no_underflow, !(pop && empty), "queue pop while empty")

endmodule

`default_nettype wire

>>> rtl/core/knps_back.sv
// Back end: sorted store of kept points, insertion and farthest-first readout.
// Depends on knps_pkg and the assertion macro header.
`default_nettype none
`include "k_nearest_points_select_macros.svh"

module knps_back
  import knps_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [KEEP_W-1:0]        cfg_keep_count,
  input  wire logic                     q_empty,
  input  item_t                         q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [COORD_BITS-1:0]  out_x,
  output logic signed [COORD_BITS-1:0]  out_y,
  output logic [DIST_W-1:0]             out_dist,
  output logic                          out_last_result
);

  typedef enum logic [1:0] {
    ST_INSERT = 2'b01,
    ST_EMIT   = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  entry_t           cell_r   [MAX_KEEP];
  entry_t           cell_nxt [MAX_KEEP];
  logic [MAX_KEEP-1:0] le;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, k_r, k_lim;
  logic [CNT_W:0]   cnt_inc;
  logic [IDX_W-1:0] rd_idx;
  logic             ins, out_load, out_valid_r, is_last;
  entry_t           out_pt_r;
  logic             out_last_r;

  // clamp keep_count to 1..MAX_KEEP
  always_comb begin
    if (cfg_keep_count == '0)
      k_lim = CNT_W'(1);
    else if ((CNT_W + KEEP_W)'(cfg_keep_count) > (CNT_W + KEEP_W)'(MAX_KEEP))
      k_lim = CNT_W'(MAX_KEEP);
    else
      k_lim = CNT_W'(cfg_keep_count);
  end

  // le is a prefix mask: entries at or nearer than the new point stay put
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++)
      le[i] = ((CNT_W + 1)'(i) < (CNT_W + 1)'(cnt_r)) &&
              (cell_r[i].sq_dist <= q_head.pt.sq_dist);
  end

  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_nxt[g] = le[g] ? cell_r[g] : q_head.pt;
    end else begin : g_rest
      assign cell_nxt[g] = le[g]     ? cell_r[g]  :
                           le[g - 1] ? q_head.pt  : cell_r[g - 1];
    end
  end

  assign ins      = (state_r == ST_INSERT) && !q_empty;
  assign q_pop    = ins;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign rd_idx   = IDX_W'(cnt_r - 1'b1);
  assign is_last  = (cnt_r == CNT_W'(1));
  assign cnt_inc  = (CNT_W + 1)'(cnt_r) + 1'b1;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_INSERT: begin
        if (ins) begin
          cnt_nxt = (cnt_inc > (CNT_W + 1)'(k_r)) ? k_r : CNT_W'(cnt_inc);
          if (q_head.set_end) state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          cnt_nxt = cnt_r - 1'b1;
          if (is_last) state_nxt = ST_INSERT;
        end
      end
      default: state_nxt = ST_INSERT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INSERT;
      cnt_r       <= '0;
      k_r         <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) k_r <= k_lim;
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      for (int i = 0; i < MAX_KEEP; i++) cell_r[i] <= cell_nxt[i];
    end
    if (out_load) begin
      out_pt_r   <= cell_r[rd_idx];
      out_last_r <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_pt_r.x;
  assign out_y           = out_pt_r.y;
  assign out_dist        = DIST_W'(out_pt_r.sq_dist);
  assign out_last_result = out_last_r;

  // a keep_count drop between sets may leave the count above k until the next insert
  `KNPS_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(MAX_KEEP), "count above store depth")
  `KNPS_ASSERT(a_emit_nonempty, (state_r != ST_EMIT) || (cnt_r != '0), "emit with empty store")
  `KNPS_IMPLY_NEXT(a_last_clears, out_load && is_last, cnt_r == '0, "store not emptied")

endmodule

`default_nettype wire

>>> rtl/core/k_nearest_points_select.sv
// Top level of k_nearest_points_select: front end, queue, back end.
// Depends on knps_pkg, knps_front, knps_queue, knps_back.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_stall, in_coord_x/y, in_set_end | point in
//  out      | out_valid, out_stall, out_x/y, out_dist,  | kept point out
//           | out_last_result                           |
//  cfg      | cfg_we, cfg_keep_count                    | keep count write
//
// A point passes the two front-end stages (square, then sum) and the queue
//   to the back end, where a row of comparators finds its slot and the whole
//   store shifts at once; sustained rate is one point per cycle while the back
//   end inserts and nothing stalls. A set_end beat starts a readout of the kept
//   points (1..keep_count) through the single read port to the output register.
// Reset clears the kept count, the queue and sets keep_count to 1; store
//   contents are left as they are.
// Either side may stall on its own; the queue decouples front and back.
`default_nettype none

module k_nearest_points_select
  import knps_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [KEEP_W-1:0]            cfg_keep_count,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_coord_x,
  input  wire logic signed [COORD_BITS-1:0] in_coord_y,
  input  wire logic                         in_set_end,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic [DIST_W-1:0]                 out_dist,
  output logic                              out_last_result
);

  push_t push;        // front -> queue beat
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  item_t q_head;

  // distance computation
  knps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_set_end (in_set_end),
    .push       (push),
    .q_full     (q_full)
  );

  // decoupling queue
  knps_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  // sorted store and readout
  knps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_keep_count  (cfg_keep_count),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_dist        (out_dist),
    .out_last_result (out_last_result)
  );

endmodule

`default_nettype wire
